/* sv/uce_pkg.sv */
// shared types and constants of the unicode code point encoder
package uce_pkg;

    // field widths
    localparam int CP_W   = 32;
    localparam int UNIT_W = 32;
    localparam int CAP_W  = 16;
    localparam int CFG_W  = 16;

    // output formats
    typedef enum logic [1:0] {
        FMT_UTF8    = 2'd0,
        FMT_UTF16LE = 2'd1,
        FMT_UTF16BE = 2'd2,
        FMT_UTF32   = 2'd3
    } fmt_t;

    // item kinds
    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    // configuration register indexes
    localparam logic REG_FORMAT   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // reset values
    localparam fmt_t             FORMAT_RST   = FMT_UTF8;
    localparam logic [CAP_W-1:0] CAPACITY_RST = 16'hFFFF;

    // code point limits
    localparam logic [CP_W-1:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [CP_W-1:0] CP_ASCII_MAX = 32'h0000_007F;
    localparam logic [CP_W-1:0] CP_2B_MAX    = 32'h0000_07FF;
    localparam logic [CP_W-1:0] CP_BMP_MAX   = 32'h0000_FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 32'h0000_D7FF;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 32'h0000_E000;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 32'h0001_0000;

    // utf-16 surrogate bases
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // utf-8 lead and continuation marks
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] CONT  = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

endpackage

/* sv/uce_if.sv */
// item and result channel interfaces of the unicode code point encoder
interface uce_item_if
    import uce_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [CP_W-1:0] codepoint;

    modport source (output valid, output kind, output codepoint, input ready);
    modport sink   (input valid, input kind, input codepoint, output ready);
endinterface

interface uce_result_if
    import uce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              accepted;
    logic              last;

    modport source (output valid, output code_unit, output unit_valid,
                    output accepted, output last, input ready);
    modport sink   (input valid, input code_unit, input unit_valid,
                    input accepted, input last, output ready);
endinterface

/* sv/unicode_codepoint_encoder.sv */
// unicode code point encoder: utf-8, utf-16 le/be and utf-32 with buffer count
//
//  channel  | dir | payload                                  | beats per item
//  ---------+-----+------------------------------------------+---------------
//  item     | in  | kind, codepoint                          | 1
//  result   | out | code_unit, unit_valid, accepted, last    | 1 to 4
//  cfg      | in  | cfg_we, cfg_index, cfg_data (no ready)   | -
//
// an item goes from the input register through the encoder into the unit
// buffer; the buffer then sends one result beat per cycle while result
// ready is high, one beat per unit, or a single beat for clear or reject;
// the first result leaves the unit buffer, which follows the input register
// the input register takes a new item while the buffer still sends units
// reset clears the count and the valid flags and sets the configuration registers to their reset values
module unicode_codepoint_encoder
    import uce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    uce_item_if.sink           item,
    uce_result_if.source       result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    // configuration and count registers
    fmt_t             fmt_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] used_reg;
    logic [CAP_W-1:0] used_next;

    // input register
    logic            s1_valid_reg;
    logic            s1_kind_reg;
    logic [CP_W-1:0] s1_cp_reg;

    // unit buffer
    logic              buf_valid_reg;
    logic [UNIT_W-1:0] units_reg [4];
    logic [1:0]        idx_reg;
    logic [1:0]        last_idx_reg;
    logic              uv_reg;
    logic              acc_reg;

    // encoder outputs
    logic [UNIT_W-1:0] enc_units [4];
    logic [2:0]        enc_n;
    logic              enc_ok;

    // handshake
    logic buf_done;
    logic buf_free;
    logic move;
    logic in_fire;
    logic out_fire;

    assign out_fire = buf_valid_reg & result.ready;
    assign buf_done = out_fire & (idx_reg == last_idx_reg);
    assign buf_free = ~buf_valid_reg | buf_done;
    assign move     = s1_valid_reg & buf_free;
    assign item.ready = ~s1_valid_reg | buf_free;
    assign in_fire  = item.valid & item.ready;

    // result beat from the buffer
    assign result.valid      = buf_valid_reg;
    assign result.code_unit  = units_reg[idx_reg];
    assign result.unit_valid = uv_reg;
    assign result.accepted   = acc_reg;
    assign result.last       = (idx_reg == last_idx_reg);

    // encode the held code point
    always_comb
    begin
        logic [CP_W-1:0] cp;
        logic [19:0]     v;
        logic [15:0]     u0;
        logic [15:0]     u1;
        logic [CAP_W:0]  sum;
        cp = s1_cp_reg;
        v  = 20'(cp - CP_SUPP_BASE);
        u0 = '0;
        u1 = '0;
        enc_units[0] = '0;
        enc_units[1] = '0;
        enc_units[2] = '0;
        enc_units[3] = '0;
        enc_n = 3'd0;
        unique case (fmt_reg)
            FMT_UTF8:
            begin
                priority if (cp <= CP_ASCII_MAX)
                begin
                    enc_units[0] = cp;
                    enc_n = 3'd1;
                end
                else if (cp <= CP_2B_MAX)
                begin
                    enc_units[0] = {24'd0, LEAD2 | {3'd0, cp[10:6]}};
                    enc_units[1] = {24'd0, CONT | ({2'd0, cp[5:0]} & CONT_MASK)};
                    enc_n = 3'd2;
                end
                else if (cp <= CP_BMP_MAX)
                begin
                    enc_units[0] = {24'd0, LEAD3 | {4'd0, cp[15:12]}};
                    enc_units[1] = {24'd0, CONT | {2'd0, cp[11:6]}};
                    enc_units[2] = {24'd0, CONT | {2'd0, cp[5:0]}};
                    enc_n = 3'd3;
                end
                else if (cp <= CP_MAX)
                begin
                    enc_units[0] = {24'd0, LEAD4 | {5'd0, cp[20:18]}};
                    enc_units[1] = {24'd0, CONT | {2'd0, cp[17:12]}};
                    enc_units[2] = {24'd0, CONT | {2'd0, cp[11:6]}};
                    enc_units[3] = {24'd0, CONT | {2'd0, cp[5:0]}};
                    enc_n = 3'd4;
                end
                else
                begin
                    enc_n = 3'd0;
                end
            end
            FMT_UTF16LE, FMT_UTF16BE:
            begin
                priority if (cp <= CP_SURR_LO || (cp >= CP_SURR_HI && cp <= CP_BMP_MAX))
                begin
                    u0 = cp[15:0];
                    enc_n = 3'd1;
                end
                else if (cp >= CP_SUPP_BASE && cp <= CP_MAX)
                begin
                    u0 = HI_SURR_BASE + {6'd0, v[19:10]};
                    u1 = LO_SURR_BASE + {6'd0, v[9:0]};
                    enc_n = 3'd2;
                end
                else
                begin
                    enc_n = 3'd0;
                end
                // big endian swaps the bytes of each unit
                if (fmt_reg == FMT_UTF16BE)
                begin
                    u0 = {u0[7:0], u0[15:8]};
                    u1 = {u1[7:0], u1[15:8]};
                end
                enc_units[0] = {16'd0, u0};
                enc_units[1] = {16'd0, u1};
            end
            FMT_UTF32:
            begin
                enc_units[0] = cp;
                enc_n = 3'd1;
            end
            default:
            begin
                enc_n = 3'd0;
            end
        endcase
        // capacity check on the widened sum
        sum = {1'b0, used_reg} + {14'd0, enc_n};
        enc_ok = (enc_n != 3'd0) && (sum <= {1'b0, cap_reg});
    end

    // next count
    always_comb
    begin
        used_next = used_reg;
        if (move)
        begin
            if (s1_kind_reg == KIND_CLEAR)
                used_next = '0;
            else if (enc_ok)
                used_next = used_reg + {13'd0, enc_n};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FORMAT_RST;
            cap_reg       <= CAPACITY_RST;
            used_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FORMAT:   fmt_reg <= fmt_t'(cfg_data[1:0]);
                    REG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                    default:      cap_reg <= cap_reg;
                endcase
            end
            used_reg <= used_next;
            // input register valid
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (move)
                s1_valid_reg <= 1'b0;
            // buffer valid and unit index
            if (move)
            begin
                buf_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (buf_done)
            begin
                buf_valid_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= item.kind;
            s1_cp_reg   <= item.codepoint;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            if (s1_kind_reg == KIND_ENCODE && enc_ok)
            begin
                units_reg[0] <= enc_units[0];
                units_reg[1] <= enc_units[1];
                units_reg[2] <= enc_units[2];
                units_reg[3] <= enc_units[3];
                last_idx_reg <= 2'(enc_n - 3'd1);
                uv_reg       <= 1'b1;
                acc_reg      <= 1'b1;
            end
            else
            begin
                // clear or reject: a single beat with no unit
                units_reg[0] <= '0;
                units_reg[1] <= '0;
                units_reg[2] <= '0;
                units_reg[3] <= '0;
                last_idx_reg <= '0;
                uv_reg       <= 1'b0;
                acc_reg      <= (s1_kind_reg == KIND_CLEAR);
            end
        end
    end

endmodule

/* sv/uce_checker.sv */
// port checker of the unicode code point encoder and its bind
module uce_checker
    import uce_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [UNIT_W-1:0] code_unit,
    input logic              unit_valid,
    input logic              accepted,
    input logic              last
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(last))
        else $error("stalled result beat changed");

    // a beat without a unit ends its item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unit_valid |-> last && code_unit == '0)
        else $error("unitless beat not last or not zero");

    // a unit beat is always an accepted one
    a_unit_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_valid |-> accepted)
        else $error("unit beat on a rejected item");

    // within a multi-unit item the flags stay the same beat to beat
    a_same_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && unit_valid && accepted)
        else $error("multi-unit item broken");

endmodule

bind unicode_codepoint_encoder uce_checker u_uce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .code_unit  (result.code_unit),
    .unit_valid (result.unit_valid),
    .accepted   (result.accepted),
    .last       (result.last)
);
